[hw/rtl/jtag_scan_sequencer_top_defines.svh]
// assertion macros used by the scan sequencer back end
`ifndef JTAG_SCAN_SEQUENCER_TOP_DEFINES_SVH
`define JTAG_SCAN_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define JSS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jss assertion failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define JSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jss assertion failed");
`else
`define JSS_ASSERT_SAME(label, ante, cons)
`define JSS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/jss_pkg.sv]
// types and constants of the jtag scan sequencer
`timescale 1ns / 1ps
`default_nettype none

package jss_pkg;

    localparam int CNT_W            = 7;
    localparam int IDLE_MAX_DEFAULT = 64;
    localparam int QDEPTH           = 2;
    localparam int QPTR_W           = $clog2(QDEPTH);
    localparam int QCNT_W           = $clog2(QDEPTH + 1);

    // command opcodes on the input channel
    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_IDLE  = 2'd1;
    localparam logic [1:0] OP_IR    = 2'd2;
    localparam logic [1:0] OP_DR    = 2'd3;

    // tap navigation lengths ahead of the first data cycle
    localparam logic [1:0] NAV_NONE = 2'd0;
    localparam logic [1:0] NAV_DR   = 2'd2;
    localparam logic [1:0] NAV_IR   = 2'd3;

    localparam logic [CNT_W-1:0] RESET_CYCLES = CNT_W'(7);
    localparam logic [CNT_W-1:0] RESET_HIGH   = CNT_W'(6);

    typedef enum logic [1:0] {
        CMD_RESET,
        CMD_IDLE,
        CMD_SHIFT
    } cmd_kind_t;

    // classified command handed from front to back
    typedef struct packed {
        cmd_kind_t        kind;
        logic [1:0]       nav;
        logic             tdi;
        logic             last_bit;
        logic             cap;
        logic [CNT_W-1:0] total;
    } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/jss_front.sv]
// front end: accepts commands, tracks the open scan and classifies
`timescale 1ns / 1ps
`default_nettype none

module jss_front
    import jss_pkg::*;
#(
    parameter int IDLE_MAX_CYCLES = IDLE_MAX_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire logic [1:0]       opcode,
    input  wire logic             tdi_bit,
    input  wire logic             last_bit,
    input  wire logic             capture_tdo,
    input  wire logic [CNT_W-1:0] idle_count,
    input  wire logic             q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    localparam logic [CNT_W-1:0] IdleMax = CNT_W'(IDLE_MAX_CYCLES);

    logic             in_scan_reg;
    logic             in_scan_next;
    logic             accept;
    logic [CNT_W-1:0] idle_sat;
    logic [1:0]       nav;

    assign cmd_ready = !q_full;
    assign accept    = cmd_valid && cmd_ready;

    always_comb
    begin
        idle_sat     = (idle_count > IdleMax) ? IdleMax : idle_count;
        nav          = in_scan_reg ? NAV_NONE : ((opcode == OP_IR) ? NAV_IR : NAV_DR);
        q_cmd        = '0;
        q_cmd.tdi    = tdi_bit;
        q_cmd.last_bit = last_bit;
        q_cmd.cap    = capture_tdo;
        q_push       = accept;
        in_scan_next = in_scan_reg;
        case (opcode)
            OP_RESET:
            begin
                q_cmd.kind  = CMD_RESET;
                q_cmd.total = RESET_CYCLES;
                if (accept)
                begin
                    in_scan_next = 1'b0;
                end
            end
            OP_IDLE:
            begin
                q_cmd.kind  = CMD_IDLE;
                q_cmd.total = idle_sat;
                // zero idle cycles leave nothing for the back end
                q_push      = accept && (idle_sat != '0);
            end
            default:
            begin
                q_cmd.kind  = CMD_SHIFT;
                q_cmd.nav   = nav;
                q_cmd.total = CNT_W'(nav) + CNT_W'(1) + (last_bit ? CNT_W'(2) : CNT_W'(0));
                if (accept)
                begin
                    in_scan_next = !last_bit;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_scan_reg <= 1'b0;
        end
        else
        begin
            in_scan_reg <= in_scan_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/jss_queue.sv]
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module jss_queue
    import jss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t wr_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      rd_valid,
    output cmd_t      rd_cmd
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/jss_back.sv]
// back end: expands the head command into tck cycles
`timescale 1ns / 1ps
`default_nettype none
`include "jtag_scan_sequencer_top_defines.svh"

module jss_back
    import jss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output logic      cyc_valid,
    input  wire logic cyc_ready,
    output logic      tms,
    output logic      tdi_out,
    output logic      capture,
    output logic      last
);

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             tms_reg;
    logic             tdi_reg;
    logic             cap_reg;
    logic             last_reg;
    logic             load;
    logic             c_tms;
    logic             c_tdi;
    logic             c_cap;
    logic             c_last;
    logic [CNT_W-1:0] nav_w;

    assign cyc_valid = out_valid_reg;
    assign tms       = tms_reg;
    assign tdi_out   = tdi_reg;
    assign capture   = cap_reg;
    assign last      = last_reg;

    // output register frees up when empty or when its transfer completes
    assign load  = q_valid && (!out_valid_reg || cyc_ready);
    assign q_pop = load && c_last;

    always_comb
    begin
        nav_w  = CNT_W'(q_cmd.nav);
        c_tms  = 1'b0;
        c_tdi  = 1'b0;
        c_cap  = 1'b0;
        c_last = (idx_reg == q_cmd.total - CNT_W'(1));
        case (q_cmd.kind)
            CMD_RESET:
            begin
                c_tms = (idx_reg < RESET_HIGH);
            end
            CMD_IDLE:
            begin
                c_tms = 1'b0;
            end
            CMD_SHIFT:
            begin
                if (idx_reg < nav_w)
                begin
                    // select-xr scan cycles, then capture with tms low
                    c_tms = (idx_reg != nav_w - CNT_W'(1));
                end
                else if (idx_reg == nav_w)
                begin
                    c_tms = q_cmd.last_bit;
                    c_tdi = q_cmd.tdi;
                    c_cap = q_cmd.cap;
                end
                else
                begin
                    // exit to update, then run-test/idle
                    c_tms = (idx_reg == nav_w + CNT_W'(1));
                end
            end
            default:
            begin
                c_tms = 1'b0;
            end
        endcase

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !cyc_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = c_last ? '0 : idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tms_reg  <= c_tms;
            tdi_reg  <= c_tdi;
            cap_reg  <= c_cap;
            last_reg <= c_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `JSS_ASSERT_SAME(a_idx_in_range, q_valid, idx_reg < q_cmd.total)
    `JSS_ASSERT_SAME(a_pop_on_final, q_pop, load && c_last)
    `JSS_ASSERT_NEXT(a_no_bubble_mid_cmd, out_valid_reg && cyc_ready && !last_reg, out_valid_reg)
    `JSS_ASSERT_NEXT(a_idx_rewinds, q_pop, idx_reg == '0)

endmodule

`default_nettype wire

[hw/rtl/jtag_scan_sequencer_top.sv]
// top level of the jtag scan sequencer: front, command queue, back
// a command is written into the queue, then loaded into the back end's output register
// throughput: one tck cycle per clock while cyc_ready is high and the queue holds a
//   command; an idle of zero is accepted but pushes nothing to the back end
// the back end's cycle counter sets the rate; the front accepts while the queue has room
// reset clears the queue, the open scan flag and the output valid at once
`timescale 1ns / 1ps
`default_nettype none

module jtag_scan_sequencer_top
    import jss_pkg::*;
#(
    parameter int IDLE_MAX_CYCLES = IDLE_MAX_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // command channel
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire logic [1:0]       opcode,
    input  wire logic             tdi_bit,
    input  wire logic             last_bit,
    input  wire logic             capture_tdo,
    input  wire logic [CNT_W-1:0] idle_count,
    // tck cycle channel
    output logic                  cyc_valid,
    input  wire logic             cyc_ready,
    output logic                  tms,
    output logic                  tdi_out,
    output logic                  capture,
    output logic                  last
);

    // classified command from front into the queue
    cmd_t fq_cmd;
    logic fq_push;
    logic fq_full;

    // head of the queue toward the back end
    cmd_t qb_cmd;
    logic qb_valid;
    logic qb_pop;

    // front tracks whether a scan is open and works out the tap navigation
    jss_front #(
        .IDLE_MAX_CYCLES (IDLE_MAX_CYCLES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .opcode      (opcode),
        .tdi_bit     (tdi_bit),
        .last_bit    (last_bit),
        .capture_tdo (capture_tdo),
        .idle_count  (idle_count),
        .q_full      (fq_full),
        .q_push      (fq_push),
        .q_cmd       (fq_cmd)
    );

    // two-entry queue lets front and back stall on their own
    jss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fq_push),
        .wr_cmd   (fq_cmd),
        .full     (fq_full),
        .pop      (qb_pop),
        .rd_valid (qb_valid),
        .rd_cmd   (qb_cmd)
    );

    // back steps through the tck cycles of the head command
    jss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_cmd     (qb_cmd),
        .q_pop     (qb_pop),
        .cyc_valid (cyc_valid),
        .cyc_ready (cyc_ready),
        .tms       (tms),
        .tdi_out   (tdi_out),
        .capture   (capture),
        .last      (last)
    );

endmodule

`default_nettype wire
